// ===== hdl/vau_pkg.sv =====
// Package for the three-component vector unit: opcodes, status codes,
// fixed-point constants and the pipeline word type. No dependencies.
`timescale 1ns / 1ps
package vau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW = 32 + FRAC_BITS;
  localparam int SW = 70;
  localparam int SQ_STEPS = 32;

  typedef enum logic [3:0] {
    FN_ADD   = 4'd0,
    FN_SUB   = 4'd1,
    FN_MUL   = 4'd2,
    FN_DIV   = 4'd3,
    FN_SCALE = 4'd4,
    FN_DIVS  = 4'd5,
    FN_LERP  = 4'd6,
    FN_LEN   = 4'd7,
    FN_NORM  = 4'd8,
    FN_DOT   = 4'd9,
    FN_EQ    = 4'd10
  } func_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    func_t                  func;
    logic [2:0][31:0]       a;
    logic [2:0][31:0]       b;
    logic [31:0]            s;
    logic [2:0][65:0]       prod;
    logic [2:0][31:0]       r;
    logic [31:0]            rs;
    logic                   eq;
    logic                   sat;
    logic                   zero;
    logic [1:0]             status;
    logic [2:0]             nneg;
    logic [2:0][31:0]       nmag;
    logic [2:0]             dneg;
    logic [2:0][31:0]       dmag;
    logic [63:0]            sqn;
    logic [31:0]            root;
    logic [33:0]            srem;
    logic [2:0][DW-1:0]     dd;
    logic [2:0][31:0]       drem;
  } pipe_t;

endpackage

// ===== hdl/vau_if.sv =====
// Channel interfaces for the vector unit: the operand word and the result word.
// No dependencies.
`timescale 1ns / 1ps
interface vau_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [31:0] a_x;
  logic [31:0] a_y;
  logic [31:0] a_z;
  logic [31:0] b_x;
  logic [31:0] b_y;
  logic [31:0] b_z;
  logic [31:0] scalar_in;
  modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  input ready);
  modport sink (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                output ready);
endinterface

interface vau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] r_x;
  logic [31:0] r_y;
  logic [31:0] r_z;
  logic [31:0] r_scalar;
  logic        is_equal;
  logic [1:0]  status;
  modport source (output valid, r_x, r_y, r_z, r_scalar, is_equal, status,
                  input ready);
  modport sink (input valid, r_x, r_y, r_z, r_scalar, is_equal, status,
                output ready);
endinterface

// ===== hdl/vec3_arithmetic_unit.sv =====
// Three-component Q16.16 vector unit: top level and its whole pipeline.
// Depends on vau_pkg and the channel interfaces in vau_if.sv.
// Usage: the unit accepts one word per cycle while input ready is high and
// returns each result through a 32-stage square-root pipeline followed by a
// 48-stage restoring divider pipeline, one result bit per stage. When the
// result word is not taken the whole pipeline holds, and input ready is low
// only while a result waits.
`timescale 1ns / 1ps
module vec3_arithmetic_unit
  import vau_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  vau_in_if.sink    in_ch,
  vau_out_if.source out_ch
);

  localparam int S_SQ0  = 3;
  localparam int S_SEL  = S_SQ0 + SQ_STEPS;
  localparam int S_DIV0 = S_SEL + 1;
  localparam int S_FIN  = S_DIV0 + DW;
  localparam int NST    = S_FIN + 1;

  pipe_t st_r [NST];
  pipe_t st_nxt [NST];
  logic  vld_r [NST];
  logic  en;

  function automatic logic signed [SW-1:0] sx(input logic [31:0] x);
    return {{(SW-32){x[31]}}, x};
  endfunction

  function automatic logic signed [SW-1:0] sx66(input logic [65:0] x);
    return {{(SW-66){x[65]}}, x};
  endfunction

  function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
    logic [32:0] o;
    if (v[SW-1:31] == '0 || v[SW-1:31] == '1) begin
      o = {1'b0, v[31:0]};
    end else begin
      o = {1'b1, v[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return o;
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  function automatic pipe_t f_prod(input pipe_t p);
    pipe_t o;
    logic signed [32:0] m1;
    logic signed [32:0] m2;
    o = p;
    for (int i = 0; i < 3; i++) begin
      if (p.func == FN_LERP) begin
        m1 = $signed({p.b[i][31], p.b[i]}) - $signed({p.a[i][31], p.a[i]});
      end else begin
        m1 = $signed({p.a[i][31], p.a[i]});
      end
      if (p.func == FN_MUL || p.func == FN_DOT) begin
        m2 = $signed({p.b[i][31], p.b[i]});
      end else if (p.func == FN_LEN || p.func == FN_NORM) begin
        m2 = $signed({p.a[i][31], p.a[i]});
      end else begin
        m2 = $signed({p.s[31], p.s});
      end
      o.prod[i] = 66'(m1 * m2);
    end
    return o;
  endfunction

  function automatic pipe_t f_comb(input pipe_t p);
    pipe_t o;
    logic signed [SW-1:0] v [3];
    logic signed [SW-1:0] dsum;
    logic [32:0] t;
    logic sat;
    o = p;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) v[i] = '0;
    dsum = sx66(p.prod[0]) + sx66(p.prod[1]) + sx66(p.prod[2]);
    o.rs = '0;
    o.eq = 1'b0;
    o.zero = 1'b0;
    o.sqn = dsum[63:0];
    o.root = '0;
    o.srem = '0;
    for (int i = 0; i < 3; i++) begin
      o.nneg[i] = p.a[i][31];
      o.nmag[i] = mag(p.a[i]);
      o.dneg[i] = (p.func == FN_DIV) ? p.b[i][31] : p.s[31];
      o.dmag[i] = (p.func == FN_DIV) ? mag(p.b[i]) : mag(p.s);
    end
    unique case (p.func)
      FN_ADD: for (int i = 0; i < 3; i++) v[i] = sx(p.a[i]) + sx(p.b[i]);
      FN_SUB: for (int i = 0; i < 3; i++) v[i] = sx(p.a[i]) - sx(p.b[i]);
      FN_MUL, FN_SCALE: begin
        for (int i = 0; i < 3; i++) v[i] = sx66(p.prod[i]) >>> FRAC_BITS;
      end
      FN_LERP: begin
        for (int i = 0; i < 3; i++) v[i] = sx(p.a[i]) + (sx66(p.prod[i]) >>> FRAC_BITS);
      end
      FN_DIV: o.zero = (p.b[0] == '0) || (p.b[1] == '0) || (p.b[2] == '0);
      FN_DIVS: o.zero = (p.s == '0);
      FN_DOT: begin
        t = sat32(dsum >>> FRAC_BITS);
        sat = t[32];
        o.rs = t[31:0];
      end
      FN_EQ: o.eq = (p.a == p.b);
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      t = sat32(v[i]);
      sat = sat | t[32];
      o.r[i] = t[31:0];
    end
    o.sat = sat;
    return o;
  endfunction

  function automatic pipe_t f_sqrt(input pipe_t p);
    pipe_t o;
    logic [35:0] rem2;
    logic [35:0] trial;
    o = p;
    rem2 = {p.srem, p.sqn[63:62]};
    trial = {2'b00, p.root, 2'b01};
    o.sqn = {p.sqn[61:0], 2'b00};
    if (rem2 >= trial) begin
      o.srem = 34'(rem2 - trial);
      o.root = {p.root[30:0], 1'b1};
    end else begin
      o.srem = rem2[33:0];
      o.root = {p.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic pipe_t f_sel(input pipe_t p);
    pipe_t o;
    logic [32:0] t;
    o = p;
    if (p.func == FN_LEN) begin
      t = sat32({{(SW-32){1'b0}}, p.root});
      o.rs = t[31:0];
      o.sat = t[32];
    end
    if (p.func == FN_NORM) begin
      o.zero = (p.root == '0);
      for (int i = 0; i < 3; i++) begin
        o.dmag[i] = p.root;
        o.dneg[i] = 1'b0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      o.dd[i] = {p.nmag[i], {FRAC_BITS{1'b0}}};
      o.drem[i] = '0;
    end
    return o;
  endfunction

  function automatic pipe_t f_div(input pipe_t p);
    pipe_t o;
    logic [32:0] t;
    logic        q;
    o = p;
    for (int i = 0; i < 3; i++) begin
      t = {p.drem[i], p.dd[i][DW-1]};
      q = (t >= {1'b0, p.dmag[i]});
      o.drem[i] = q ? 32'(t - {1'b0, p.dmag[i]}) : t[31:0];
      o.dd[i] = {p.dd[i][DW-2:0], q};
    end
    return o;
  endfunction

  function automatic pipe_t f_fin(input pipe_t p);
    pipe_t o;
    logic signed [SW-1:0] v;
    logic [32:0] t;
    logic sat;
    o = p;
    sat = p.sat;
    if (p.func == FN_DIV || p.func == FN_DIVS || p.func == FN_NORM) begin
      for (int i = 0; i < 3; i++) begin
        v = {{(SW-DW){1'b0}}, p.dd[i]};
        if (p.nneg[i] ^ p.dneg[i]) v = -v;
        t = sat32(v);
        o.r[i] = p.zero ? 32'd0 : t[31:0];
        sat = sat | (t[32] & ~p.zero);
      end
    end
    if (p.zero) begin
      o.status = ST_ZERO;
    end else if (sat) begin
      o.status = ST_SAT;
    end else begin
      o.status = ST_OK;
    end
    return o;
  endfunction

  always_comb begin
    st_nxt[0] = st_r[0];
    st_nxt[0].func = func_t'(in_ch.func);
    st_nxt[0].a = {in_ch.a_z, in_ch.a_y, in_ch.a_x};
    st_nxt[0].b = {in_ch.b_z, in_ch.b_y, in_ch.b_x};
    st_nxt[0].s = in_ch.scalar_in;
    st_nxt[0].r = '0;
    st_nxt[0].sat = 1'b0;
  end

  for (genvar g = 1; g < NST; g++) begin : g_stage
    always_comb begin
      if (g == 1) begin
        st_nxt[g] = f_prod(st_r[g-1]);
      end else if (g == 2) begin
        st_nxt[g] = f_comb(st_r[g-1]);
      end else if (g < S_SEL) begin
        st_nxt[g] = f_sqrt(st_r[g-1]);
      end else if (g == S_SEL) begin
        st_nxt[g] = f_sel(st_r[g-1]);
      end else if (g < S_FIN) begin
        st_nxt[g] = f_div(st_r[g-1]);
      end else begin
        st_nxt[g] = f_fin(st_r[g-1]);
      end
    end
  end

  assign en = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign out_ch.valid    = vld_r[NST-1];
  assign out_ch.r_x      = st_r[NST-1].r[0];
  assign out_ch.r_y      = st_r[NST-1].r[1];
  assign out_ch.r_z      = st_r[NST-1].r[2];
  assign out_ch.r_scalar = st_r[NST-1].rs;
  assign out_ch.is_equal = st_r[NST-1].eq;
  assign out_ch.status   = st_r[NST-1].status;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status != 2'd3)
    else $error("status code out of range");
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_ZERO |->
      out_ch.r_x == '0 && out_ch.r_y == '0 && out_ch.r_z == '0)
    else $error("zero status with nonzero vector");
  a_eq_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_equal |-> out_ch.status == ST_OK && out_ch.r_scalar == '0)
    else $error("equal result with status or scalar");
`endif

endmodule

// ===== sim/vec3_arithmetic_unit_checker.sv =====
// Result checker for the vector unit: watches both channels, predicts each
// result word and compares it field by field. Depends on vau_pkg and vau_if.sv.
`timescale 1ns / 1ps
module vec3_arithmetic_unit_checker
  import vau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  vau_in_if         in_ch,
  vau_out_if        out_ch,
  output int        fail_count,
  output int        pending,
  output logic      any_accept
);

  typedef struct packed {
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [31:0] r_scalar;
    logic        is_equal;
    logic [1:0]  status;
  } vec_result_t;

  vec_result_t expected_q[$];

  initial fail_count = 0;
  assign pending = expected_q.size();
  assign any_accept = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);

  function automatic longint clamp32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint floor_shift(input longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint quot(input longint n, input longint d);
    return (n * (64'sd1 <<< FRAC_BITS)) / d;
  endfunction

  function automatic longint root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic vec_result_t compute_vec(input logic [3:0] fn,
                                              input logic [2:0][31:0] av,
                                              input logic [2:0][31:0] bv,
                                              input logic [31:0] sv);
    longint a[3];
    longint b[3];
    longint r[3];
    longint s;
    longint rs;
    longint hi;
    longint lo;
    longint p;
    longint len;
    logic [63:0] sq;
    bit sat;
    logic [1:0] st;
    logic eq;
    vec_result_t res;
    s = longint'($signed(sv));
    rs = 0;
    sat = 0;
    st = ST_OK;
    eq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(av[i]));
      b[i] = longint'($signed(bv[i]));
      r[i] = 0;
    end
    case (fn)
      FN_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], sat);
      FN_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], sat);
      FN_MUL: for (int i = 0; i < 3; i++) r[i] = clamp32(floor_shift(a[i] * b[i]), sat);
      FN_DIV: begin
        if (b[0] == 0 || b[1] == 0 || b[2] == 0) st = ST_ZERO;
        else for (int i = 0; i < 3; i++) r[i] = clamp32(quot(a[i], b[i]), sat);
      end
      FN_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32(floor_shift(a[i] * s), sat);
      FN_DIVS: begin
        if (s == 0) st = ST_ZERO;
        else for (int i = 0; i < 3; i++) r[i] = clamp32(quot(a[i], s), sat);
      end
      FN_LERP: for (int i = 0; i < 3; i++)
        r[i] = clamp32(a[i] + floor_shift((b[i] - a[i]) * s), sat);
      FN_LEN, FN_NORM: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + 64'(a[i] * a[i]);
        len = root_floor(sq);
        if (fn == FN_LEN) rs = clamp32(len, sat);
        else if (len == 0) st = ST_ZERO;
        else for (int i = 0; i < 3; i++) r[i] = clamp32(quot(a[i], len), sat);
      end
      FN_DOT: begin
        hi = 0;
        lo = 0;
        for (int i = 0; i < 3; i++) begin
          p = a[i] * b[i];
          hi += floor_shift(p);
          lo += p & ((64'sd1 <<< FRAC_BITS) - 1);
        end
        rs = clamp32(hi + floor_shift(lo), sat);
      end
      FN_EQ: eq = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]);
      default: ;
    endcase
    if (sat && st == ST_OK) st = ST_SAT;
    res.r_x = r[0][31:0];
    res.r_y = r[1][31:0];
    res.r_z = r[2][31:0];
    res.r_scalar = rs[31:0];
    res.is_equal = eq;
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    vec_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(compute_vec(in_ch.func, {in_ch.a_z, in_ch.a_y, in_ch.a_x},
                                         {in_ch.b_z, in_ch.b_y, in_ch.b_x},
                                         in_ch.scalar_in));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.r_x !== want.r_x) report_mismatch("r_x", out_ch.r_x, want.r_x);
          if (out_ch.r_y !== want.r_y) report_mismatch("r_y", out_ch.r_y, want.r_y);
          if (out_ch.r_z !== want.r_z) report_mismatch("r_z", out_ch.r_z, want.r_z);
          if (out_ch.r_scalar !== want.r_scalar)
            report_mismatch("r_scalar", out_ch.r_scalar, want.r_scalar);
          if (out_ch.is_equal !== want.is_equal)
            report_mismatch("is_equal", out_ch.is_equal, want.is_equal);
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
        end
      end
    end
  end

endmodule

// ===== sim/vec3_arithmetic_unit_test.sv =====
// Testbench top for the vector unit: clock, reset, operand stimulus, receiver
// stalls and verdict. Depends on vau_pkg, vau_if.sv and the result checker.
`timescale 1ns / 1ps
module vec3_arithmetic_unit_test
  import vau_pkg::*;
;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  logic any_accept;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   long_hold;
  int   quiet_cycles;

  vau_in_if  in_ch();
  vau_out_if out_ch();

  vec3_arithmetic_unit u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  vec3_arithmetic_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .any_accept(any_accept)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.func = 0;
    in_ch.a_x = 0;
    in_ch.a_y = 0;
    in_ch.a_z = 0;
    in_ch.b_x = 0;
    in_ch.b_y = 0;
    in_ch.b_z = 0;
    in_ch.scalar_in = 0;
    out_ch.ready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 0;
  end

  always @(posedge clk) begin
    if (!rst_n || !any_accept) quiet_cycles <= quiet_cycles + 1;
    else quiet_cycles <= 0;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if (long_hold) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3: return 32'h00010000;
      4: return $urandom_range(32'h3ffff) - 32'h1ffff;
      5: return $urandom_range(32'hffff);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [3:0] fn, input logic [2:0][31:0] av,
                           input logic [2:0][31:0] bv, input logic [31:0] sv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.func <= fn;
    {in_ch.a_z, in_ch.a_y, in_ch.a_x} <= av;
    {in_ch.b_z, in_ch.b_y, in_ch.b_x} <= bv;
    in_ch.scalar_in <= sv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random();
    logic [2:0][31:0] av;
    logic [2:0][31:0] bv;
    logic [3:0] fn;
    for (int i = 0; i < 3; i++) begin
      av[i] = pick_value();
      bv[i] = ($urandom_range(7) == 0) ? av[i] : pick_value();
    end
    fn = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
    send_word(fn, av, bv, pick_value());
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0][31:0] mx;
    logic [2:0][31:0] mn;
    logic [2:0][31:0] zr;
    logic [2:0][31:0] one;
    mx = {3{32'h7fffffff}};
    mn = {3{32'h80000000}};
    zr = '0;
    one = {3{32'h00010000}};
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int f = 0; f < 11; f++) send_word(4'(f), mx, mn, 32'h7fffffff);
    send_word(FN_DIV, one, {32'h1, 32'h0, 32'h1}, 0);
    send_word(FN_DIVS, mx, one, 0);
    send_word(FN_NORM, zr, one, 0);
    send_word(FN_NORM, mn, one, 0);
    send_word(FN_LEN, mn, zr, 0);
    send_word(FN_LERP, mn, mx, 32'h80000000);
    send_word(FN_EQ, one, one, 0);
    send_word(FN_DOT, mn, mn, 0);
    send_word(FN_MUL, mn, mn, 0);
    send_word(4'd15, mx, mx, 32'hffffffff);
    send_word(4'd11, one, zr, 32'h1);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 33 : 51) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 33 : 51) : 0;
      if (phase == 0) begin
        fork
          begin
            long_hold = 1;
            repeat (400) @(posedge clk);
            long_hold = 0;
          end
          repeat (200) send_random();
        join
      end else begin
        repeat (210) send_random();
      end
      drain();
    end
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
